/* src/lpmr_pkg.sv */
package lpmr_pkg;

    localparam int RING_BYTES   = 4096;
    localparam int MAX_MESSAGE  = 64;
    localparam int HEADER_BYTES = 4;
    localparam int QUEUE_DEPTH  = 4;

    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int USED_W = $clog2(RING_BYTES + 1);
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int OFF_W  = LEN_W + 1;
    localparam int SUM_W  = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_TOO_LONG = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_PUT_FIRST,
        OP_PUT_NEXT,
        OP_GET
    } op_t;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  msg_len;
        logic              put_last;
        logic [LEN_W-1:0]  max_len;
    } req_item_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [LEN_W-1:0]  stored_len;
        logic              last;
    } rsp_item_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  len;
        logic              oversize;
        logic              put_last;
        logic [LEN_W-1:0]  max_len;
    } cmd_t;

    typedef struct packed {
        logic nonempty;
        logic full;
    } qstat_t;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [OFF_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(RING_BYTES))
        begin
            s = s - SUM_W'(RING_BYTES);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

/* src/lpmr_front.sv */
module lpmr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lpmr_pkg::req_item_t req,
    input  lpmr_pkg::qstat_t    qstat,
    output logic                push,
    output lpmr_pkg::cmd_t      cmd
);
    import lpmr_pkg::*;

    logic             put_active_reg;
    logic             put_active_next;
    logic [LEN_W-1:0] put_len_reg;
    logic [LEN_W-1:0] put_len_next;
    logic [LEN_W-1:0] len_now;

    assign req_ready = !qstat.full;
    assign push      = req_valid && req_ready;

    // first put transaction of a message latches its length
    assign len_now = put_active_reg ? put_len_reg : req.msg_len;

    always_comb
    begin
        cmd.data_byte = req.data_byte;
        cmd.len       = len_now;
        cmd.oversize  = (len_now > LEN_W'(MAX_MESSAGE));
        cmd.put_last  = req.put_last;
        cmd.max_len   = req.max_len;
        if (req.mode)
        begin
            cmd.op = OP_GET;
        end
        else if (put_active_reg)
        begin
            cmd.op = OP_PUT_NEXT;
        end
        else
        begin
            cmd.op = OP_PUT_FIRST;
        end
    end

    always_comb
    begin
        put_active_next = put_active_reg;
        put_len_next    = put_len_reg;
        if (push && !req.mode)
        begin
            put_active_next = !req.put_last;
            put_len_next    = len_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            put_active_reg <= 1'b0;
            put_len_reg    <= '0;
        end
        else
        begin
            put_active_reg <= put_active_next;
            put_len_reg    <= put_len_next;
        end
    end

endmodule

/* src/lpmr_queue.sv */
module lpmr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lpmr_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output lpmr_pkg::cmd_t   head,
    output lpmr_pkg::qstat_t qstat
);
    import lpmr_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.nonempty = (count_reg != '0);
    assign qstat.full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head           = entry_reg[rd_ptr_reg];
    assign do_push        = push && !qstat.full;
    assign do_pop         = pop && qstat.nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/lpmr_back.sv */
module lpmr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lpmr_pkg::cmd_t      head,
    input  lpmr_pkg::qstat_t    qstat,
    output logic                pop,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lpmr_pkg::rsp_item_t rsp
);
    import lpmr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_GET_LEN,
        ST_GET_BYTE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [PTR_W-1:0]  read_pos_reg;
    logic [PTR_W-1:0]  read_pos_next;
    logic [PTR_W-1:0]  write_pos_reg;
    logic [PTR_W-1:0]  write_pos_next;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;
    logic              dropping_reg;
    logic              dropping_next;
    logic [LEN_W-1:0]  put_count_reg;
    logic [LEN_W-1:0]  put_count_next;
    logic [LEN_W-1:0]  get_idx_reg;
    logic [LEN_W-1:0]  get_idx_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  max_len_reg;
    logic [LEN_W-1:0]  max_len_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_item_t         rsp_reg;
    rsp_item_t         rsp_next;

    logic [BYTE_W-1:0] mem [RING_BYTES];
    logic [BYTE_W-1:0] q_reg;
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;

    logic              out_free;
    logic              emit;
    rsp_item_t         emit_item;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic              drop_now;
        logic [LEN_W-1:0]  cnt_base;
        logic [USED_W:0]   need;
        logic [LEN_W-1:0]  hdr_len;
        logic              final_byte;

        state_next     = state_reg;
        read_pos_next  = read_pos_reg;
        write_pos_next = write_pos_reg;
        used_next      = used_reg;
        dropping_next  = dropping_reg;
        put_count_next = put_count_reg;
        get_idx_next   = get_idx_reg;
        len_next       = len_reg;
        max_len_next   = max_len_reg;
        pop            = 1'b0;
        we             = 1'b0;
        waddr          = write_pos_reg;
        wdata          = '0;
        re             = 1'b0;
        raddr          = read_pos_reg;
        emit           = 1'b0;
        emit_item      = '0;
        emit_item.last = 1'b1;
        drop_now       = dropping_reg;
        cnt_base       = put_count_reg;
        need           = (USED_W + 1)'(used_reg) + (USED_W + 1)'(head.len)
                         + (USED_W + 1)'(HEADER_BYTES);
        hdr_len        = (q_reg > BYTE_W'(MAX_MESSAGE)) ? LEN_W'(MAX_MESSAGE)
                                                        : q_reg[LEN_W-1:0];
        final_byte     = (get_idx_reg == len_reg - 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (qstat.nonempty)
                begin
                    unique case (head.op) inside
                        OP_PUT_FIRST, OP_PUT_NEXT:
                        begin
                            if (out_free)
                            begin
                                if (head.op == OP_PUT_FIRST)
                                begin
                                    drop_now = head.oversize
                                               || (need > (USED_W + 1)'(RING_BYTES));
                                    cnt_base = '0;
                                end
                                put_count_next = cnt_base;
                                if (!drop_now && cnt_base < head.len)
                                begin
                                    we    = 1'b1;
                                    waddr = ring_add(write_pos_reg,
                                                     OFF_W'(HEADER_BYTES) + OFF_W'(cnt_base));
                                    wdata = head.data_byte;
                                    put_count_next = cnt_base + 1'b1;
                                end
                                pop = 1'b1;
                                if (!head.put_last)
                                begin
                                    dropping_next = drop_now;
                                    emit          = 1'b1;
                                end
                                else if (drop_now)
                                begin
                                    dropping_next    = 1'b0;
                                    put_count_next   = '0;
                                    emit             = 1'b1;
                                    emit_item.status = STATUS_FULL;
                                end
                                else
                                begin
                                    dropping_next = 1'b0;
                                    len_next      = head.len;
                                    state_next    = ST_PAD;
                                end
                            end
                        end
                        OP_GET:
                        begin
                            if (used_reg == '0)
                            begin
                                if (out_free)
                                begin
                                    pop              = 1'b1;
                                    emit             = 1'b1;
                                    emit_item.status = STATUS_EMPTY;
                                end
                            end
                            else
                            begin
                                re           = 1'b1;
                                raddr        = read_pos_reg;
                                max_len_next = head.max_len;
                                pop          = 1'b1;
                                state_next   = ST_GET_LEN;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                // zero fill for a short message, then header and commit
                if (put_count_reg < len_reg)
                begin
                    we    = 1'b1;
                    waddr = ring_add(write_pos_reg,
                                     OFF_W'(HEADER_BYTES) + OFF_W'(put_count_reg));
                    wdata = '0;
                    put_count_next = put_count_reg + 1'b1;
                end
                else if (out_free)
                begin
                    we             = 1'b1;
                    waddr          = write_pos_reg;
                    wdata          = BYTE_W'(len_reg);
                    write_pos_next = ring_add(write_pos_reg,
                                              OFF_W'(HEADER_BYTES) + OFF_W'(len_reg));
                    used_next      = used_reg + USED_W'(HEADER_BYTES) + USED_W'(len_reg);
                    put_count_next = '0;
                    emit           = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_GET_LEN:
            begin
                if (hdr_len > max_len_reg)
                begin
                    if (out_free)
                    begin
                        emit                 = 1'b1;
                        emit_item.status     = STATUS_TOO_LONG;
                        emit_item.stored_len = hdr_len;
                        state_next           = ST_IDLE;
                    end
                end
                else if (hdr_len == '0)
                begin
                    if (out_free)
                    begin
                        emit          = 1'b1;
                        read_pos_next = ring_add(read_pos_reg, OFF_W'(HEADER_BYTES));
                        used_next     = used_reg - USED_W'(HEADER_BYTES);
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    re           = 1'b1;
                    raddr        = ring_add(read_pos_reg, OFF_W'(HEADER_BYTES));
                    len_next     = hdr_len;
                    get_idx_next = '0;
                    state_next   = ST_GET_BYTE;
                end
            end
            ST_GET_BYTE:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_item.out_byte   = q_reg;
                    emit_item.byte_valid = 1'b1;
                    emit_item.stored_len = len_reg;
                    emit_item.last       = final_byte;
                    if (final_byte)
                    begin
                        read_pos_next = ring_add(read_pos_reg,
                                                 OFF_W'(HEADER_BYTES) + OFF_W'(len_reg));
                        used_next     = used_reg - USED_W'(HEADER_BYTES) - USED_W'(len_reg);
                        get_idx_next  = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        re           = 1'b1;
                        raddr        = ring_add(read_pos_reg, OFF_W'(HEADER_BYTES)
                                                + OFF_W'(get_idx_reg) + 1'b1);
                        get_idx_next = get_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next       = emit ? emit_item : rsp_reg;
        rsp_valid_next = emit ? 1'b1 : (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            read_pos_reg  <= '0;
            write_pos_reg <= '0;
            used_reg      <= '0;
            dropping_reg  <= 1'b0;
            put_count_reg <= '0;
            get_idx_reg   <= '0;
            len_reg       <= '0;
            max_len_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            read_pos_reg  <= read_pos_next;
            write_pos_reg <= write_pos_next;
            used_reg      <= used_next;
            dropping_reg  <= dropping_next;
            put_count_reg <= put_count_next;
            get_idx_reg   <= get_idx_next;
            len_reg       <= len_next;
            max_len_reg   <= max_len_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

/* src/length_prefixed_message_ring.sv */
// Byte ring of 4096 entries holding whole messages, each stored as a 4-byte length header
// and its data. A put transaction carries one byte of a message; the first byte checks size
// and free space for length plus header; a message over 64 bytes or that does not fit is
// dropped, with full reported on its last byte. A get transaction returns the oldest
// committed message one result per byte, or reports empty, or reports too long and leaves
// the message in place. A 4-entry command queue sits between the request side and the ring
// engine, so requests keep flowing while results are held. The engine has one write and one
// registered read port on the ring: the last byte of a message is followed by zero fill for
// missing bytes, then header write and commit; a get that is not empty first reads the
// header, then the message bytes. Output backpressure can stall the engine. No clearing
// pass is needed.
module length_prefixed_message_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lpmr_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lpmr_pkg::rsp_item_t rsp
);
    import lpmr_pkg::*;

    logic   push;
    logic   pop;
    cmd_t   cmd;
    cmd_t   head;
    qstat_t qstat;

    lpmr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .qstat     (qstat),
        .push      (push),
        .cmd       (cmd)
    );

    lpmr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    lpmr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* src/lpmr_checker.sv */
module lpmr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input lpmr_pkg::req_item_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input lpmr_pkg::rsp_item_t rsp
);
    import lpmr_pkg::*;

    // offered request transaction waits unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

    // held result transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.byte_valid |-> rsp.status == STATUS_OK && rsp.stored_len != '0)
    else $error("data byte with bad status or length");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STATUS_OK |-> rsp.last && !rsp.byte_valid)
    else $error("error status not a single final result");

    // bytes of one message share its length
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp.byte_valid && !rsp.last
        |=> !rsp_valid || (rsp.byte_valid && rsp.stored_len == $past(rsp.stored_len)))
    else $error("message bytes interrupted");

endmodule

bind length_prefixed_message_ring lpmr_checker u_lpmr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
